// ----- sv/deq_pkg.sv -----
package deq_pkg;

  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // stream payload widths, rounded up to whole bytes
  localparam int IN_BITS     = 2 + WORD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + CNT_W + 2 * WORD_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    count_t  entry_count;
    word_t   front_value;
    word_t   back_value;
    logic    is_empty;
  } res_t;

  // base + offset modulo DEPTH, offset no larger than DEPTH
  function automatic addr_t wrap_add(addr_t base, count_t offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(DEPTH)) sum = sum - (CNT_W + 1)'(DEPTH);
    return addr_t'(sum);
  endfunction

  function automatic addr_t wrap_dec(addr_t idx);
    return (idx == '0) ? addr_t'(DEPTH - 1) : idx - addr_t'(1);
  endfunction

endpackage

// ----- sv/deq_ram.sv -----
module deq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic [WIDTH-1:0]         rd_data0,
  output logic [WIDTH-1:0]         rd_data1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

// ----- sv/deq_ctrl.sv -----
module deq_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                out_free,
  output deq_pkg::res_t                       res,
  output logic                                wr_en,
  output deq_pkg::addr_t                      wr_addr,
  output deq_pkg::word_t                      wr_data,
  output deq_pkg::addr_t                      rd_addr0,
  output deq_pkg::addr_t                      rd_addr1,
  input  deq_pkg::word_t                      rd_data0,
  input  deq_pkg::word_t                      rd_data1
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t            state;
  deq_pkg::addr_t    head;
  deq_pkg::count_t   count;
  deq_pkg::status_t  status;

  deq_pkg::addr_t    head_next;
  deq_pkg::count_t   count_next;
  deq_pkg::status_t  status_next;
  deq_pkg::opcode_t  op;
  logic              acc;
  logic              full;
  logic              empty;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign op       = deq_pkg::opcode_t'(s_tdata[1:0]);
  assign wr_data  = deq_pkg::word_t'(s_tdata[2 +: deq_pkg::WORD_W]);
  assign full     = (count == deq_pkg::count_t'(deq_pkg::DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = deq_pkg::ST_OK;
    wr_en       = 1'b0;
    wr_addr     = deq_pkg::wrap_add(head, count);
    unique case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          wr_en      = acc;
          count_next = count + deq_pkg::count_t'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        wr_addr = deq_pkg::wrap_dec(head);
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          wr_en      = acc;
          head_next  = deq_pkg::wrap_dec(head);
          count_next = count + deq_pkg::count_t'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) status_next = deq_pkg::ST_EMPTY;
        else count_next = count - deq_pkg::count_t'(1);
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          head_next  = deq_pkg::wrap_add(head, deq_pkg::count_t'(1));
          count_next = count - deq_pkg::count_t'(1);
        end
      end
    endcase
  end

  // reads go out the cycle after the write, so no bypass is needed
  assign rd_addr0 = head;
  assign rd_addr1 = empty ? head : deq_pkg::wrap_add(head, count - deq_pkg::count_t'(1));

  always_comb begin
    res.valid       = (state == S_DONE) && out_free;
    res.status      = status;
    res.entry_count = count;
    res.front_value = empty ? '0 : rd_data0;
    res.back_value  = empty ? '0 : rd_data1;
    res.is_empty    = empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      status <= deq_pkg::ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            head   <= head_next;
            count  <= count_next;
            status <= status_next;
            state  <= S_READ;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= deq_pkg::count_t'(deq_pkg::DEPTH))
    else $error("entry count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < deq_pkg::addr_t'(deq_pkg::DEPTH - 1) || head == deq_pkg::addr_t'(deq_pkg::DEPTH - 1))
    else $error("head index out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    acc && wr_en |=> count == $past(count) + deq_pkg::count_t'(1))
    else $error("accepted push did not grow the count");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    acc && status_next != deq_pkg::ST_OK |=> $stable(count) && $stable(head))
    else $error("rejected transaction changed state");

  a_write_only_accept: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> acc && !full)
    else $error("store written outside an accepted push");
`endif

endmodule

// ----- sv/double_ended_queue.sv -----
// Bounded deque of signed words held in a 64-entry ring store (head index + count).
// An input transaction passes the S_READ and S_DONE states and the output register before result valid.
// A new transaction is taken only after the last one has passed write, registered dual read and result load.
// A new input is taken while a finished result still waits on the output register.
// Synchronous active-high reset empties the queue; store contents are left as they are.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [1:0] opcode, [33:2] push_value, rest zero
  input  logic [deq_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] status, [8:2] entry_count, [40:9] front_value, [72:41] back_value,
  // [73] is_empty, rest zero
  output logic [deq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  deq_pkg::res_t  res;
  logic           out_free;
  logic           wr_en;
  deq_pkg::addr_t wr_addr;
  deq_pkg::word_t wr_data;
  deq_pkg::addr_t rd_addr0;
  deq_pkg::addr_t rd_addr1;
  deq_pkg::word_t rd_data0;
  deq_pkg::word_t rd_data1;

  assign out_free = !m_tvalid || m_tready;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .out_free (out_free),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  deq_ram #(
    .DEPTH (deq_pkg::DEPTH),
    .WIDTH (deq_pkg::WORD_W)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= deq_pkg::OUT_TDATA_W'({res.is_empty, res.back_value, res.front_value,
                                        res.entry_count, res.status});
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int STALL_PCT    = 14;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int SETTLE       = 10;

  localparam deq_pkg::word_t WORD_MAX = 32'h7fff_ffff;
  localparam deq_pkg::word_t WORD_MIN = 32'h8000_0000;

  typedef struct {
    deq_pkg::status_t status;
    deq_pkg::count_t  entry_count;
    deq_pkg::word_t   front_value;
    deq_pkg::word_t   back_value;
    logic             is_empty;
  } deque_view_t;

  // Shadow deque: applies each accepted operation and queues the view it should produce.
  class deque_scoreboard;
    deq_pkg::word_t ring[deq_pkg::DEPTH];
    int unsigned    head = 0;
    int unsigned    fill = 0;
    deque_view_t    expected_views[$];
    int unsigned    errors = 0;

    function void note_op(deq_pkg::opcode_t op, deq_pkg::word_t word);
      deque_view_t v;
      v.status = deq_pkg::ST_OK;
      case (op)
        deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
          if (fill == deq_pkg::DEPTH) begin
            v.status = deq_pkg::ST_FULL;
          end else if (op == deq_pkg::OP_PUSH_BACK) begin
            ring[(head + fill) % deq_pkg::DEPTH] = word;
            fill++;
          end else begin
            head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            ring[head] = word;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            v.status = deq_pkg::ST_EMPTY;
          end else begin
            // pop back leaves the head where it is, even on the last word
            if (op == deq_pkg::OP_POP_FRONT) head = (head + 1) % deq_pkg::DEPTH;
            fill--;
          end
        end
      endcase
      v.entry_count = deq_pkg::count_t'(fill);
      v.is_empty    = (fill == 0);
      v.front_value = (fill == 0) ? '0 : ring[head];
      v.back_value  = (fill == 0) ? '0 : ring[(head + fill - 1) % deq_pkg::DEPTH];
      expected_views.push_back(v);
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [deq_pkg::OUT_TDATA_W-1:0] data);
      deque_view_t want;
      if (expected_views.size() == 0) begin
        $error("result transaction with no pending operation: %h", data);
        errors++;
        return;
      end
      want = expected_views.pop_front();
      compare("status", want.status, data[1:0]);
      compare("entry_count", want.entry_count, data[8:2]);
      compare("front_value", want.front_value, $signed(data[40:9]));
      compare("back_value", want.back_value, $signed(data[72:41]));
      compare("is_empty", want.is_empty, data[73]);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata;

  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  deque_scoreboard sb = new;

  double_ended_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor + watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) begin
        sb.note_op(deq_pkg::opcode_t'(s_tdata[1:0]), deq_pkg::word_t'(s_tdata[33:2]));
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_op(deq_pkg::opcode_t op, deq_pkg::word_t word);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(deq_pkg::IN_TDATA_W - deq_pkg::IN_BITS){1'b0}}, word, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(int push_pct);
    deq_pkg::opcode_t op;
    deq_pkg::word_t   word;
    if ($urandom_range(99) < push_pct) op = deq_pkg::opcode_t'($urandom_range(1));
    else op = deq_pkg::opcode_t'(2 + $urandom_range(1));
    case ($urandom_range(15))
      0: word = WORD_MAX;
      1: word = WORD_MIN;
      2: word = '0;
      3: word = '1;
      default: word = deq_pkg::word_t'($urandom);
    endcase
    send_op(op, word);
  endtask

  // output side: random backpressure, one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= STALL_PCT);
      end
    end
  end

  initial begin
    int phase_left;
    int push_pct;
    phase_left = 120;
    push_pct   = 85;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // pops on empty, last-word pops from both ends, word extremes
    send_op(deq_pkg::OP_POP_BACK, 32'sd5);
    send_op(deq_pkg::OP_POP_FRONT, 32'sd7);
    send_op(deq_pkg::OP_PUSH_BACK, WORD_MAX);
    send_op(deq_pkg::OP_POP_BACK, '0);
    send_op(deq_pkg::OP_PUSH_FRONT, WORD_MIN);
    send_op(deq_pkg::OP_POP_FRONT, '0);
    send_op(deq_pkg::OP_PUSH_BACK, '0);
    send_op(deq_pkg::OP_PUSH_BACK, '1);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(deq_pkg::OP_POP_BACK, '1);
    send_op(deq_pkg::OP_POP_FRONT, '1);
    send_op(deq_pkg::OP_POP_BACK, WORD_MIN);
    send_op(deq_pkg::OP_POP_FRONT, WORD_MAX);
    send_op(deq_pkg::OP_POP_FRONT, '0);
    send_op(deq_pkg::OP_PUSH_FRONT, WORD_MAX);
    send_op(deq_pkg::OP_PUSH_BACK, WORD_MIN);
    send_op(deq_pkg::OP_POP_BACK, '0);
    send_op(deq_pkg::OP_POP_BACK, '0);

    // phases biased toward filling or draining, or balanced, so full and empty are hit often
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(150, 40);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      quiet = (n >= 700 && n < 1000);
      if (n == 300) hold_req = 1'b1;
      send_random(push_pct);
      phase_left--;
    end
    s_tvalid <= 1'b0;

    // wait so the monitor has noted the last transaction
    @(posedge clk);
    while (sb.expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.expected_views.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/double_ended_queue.sv
sim/tb.sv
